[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers, compiled away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at every rising edge outside reset.
`define TLR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Check that expr never holds outside reset.
`define TLR_ASSERT_NEVER(label, clk, rst, expr) \
  `TLR_ASSERT(label, clk, rst, !(expr))

`else

`define TLR_ASSERT(label, clk, rst, prop)
`define TLR_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

[rtl/tlr_pkg.sv]
// ---------------------------------------------------------------------------
// tlr_pkg
// Shared types and constants of the terminated line receiver.
// ---------------------------------------------------------------------------
package tlr_pkg;

  // Default line buffer size in bytes
  localparam int LINE_SIZE_DEF = 32;

  // Byte width of the data path
  localparam int DATA_W = 8;

  // Terminator value after reset (carriage return)
  localparam logic [DATA_W-1:0] TERM_RESET = 8'd13;

  // Input item modes
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Line status codes
  typedef enum logic [1:0] {
    ST_EMPTY    = 2'd0,
    ST_READY    = 2'd1,
    ST_OVERFLOW = 2'd2
  } line_status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_NOTE
  } seq_state_t;

endpackage

[rtl/tlr_ifs.sv]
// ---------------------------------------------------------------------------
// tlr interfaces
// Valid/ready channels of the terminated line receiver.
// ---------------------------------------------------------------------------

// Input items: received byte or read request
interface tlr_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [tlr_pkg::DATA_W-1:0]  rx_byte;
  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

// Result items: line characters
interface tlr_out_if;
  logic                        valid;
  logic                        ready;
  logic [tlr_pkg::DATA_W-1:0]  out_char;
  logic                        char_valid;
  logic                        last;
  logic [1:0]                  line_state;
  modport source (output valid, output out_char, output char_valid, output last,
                  output line_state, input ready);
  modport sink   (input valid, input out_char, input char_valid, input last,
                  input line_state, output ready);
endinterface

// Configuration writes: terminator character
interface tlr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tlr_pkg::DATA_W-1:0]  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/tlr_ram.sv]
// ---------------------------------------------------------------------------
// tlr_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module tlr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/terminated_line_receiver_core.sv]
// ---------------------------------------------------------------------------
// terminated_line_receiver_core
// Collects received bytes into one line and reads the line back out.
// ---------------------------------------------------------------------------
// A received byte gives no result; while the status is empty, a byte that is
// not the terminator and finds the line not full is written into the line RAM.
// A read of a ready line of L characters puts out one character per cycle
// while the output is free: each fetch issues a RAM read whose registered data
// is loaded into the output register. The next input transaction is accepted
// after the L fetches, the load of the final character in the drain state and
// the return to idle. A read with no non-empty line ready gives one empty
// result, and the next input waits until it is loaded once the output register
// is free. Output stalls hold the read sequencer. All results of a read report
// the empty status, as the read clears it.
`include "assert_macros.svh"

module terminated_line_receiver_core #(
  parameter int LINE_SIZE = tlr_pkg::LINE_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tlr_in_if.sink    rx_in,
  tlr_out_if.source line_out,
  tlr_cfg_if.sink   cfg
);

  localparam int CW = $clog2(LINE_SIZE);
  localparam logic [CW-1:0] LAST_SLOT = CW'(LINE_SIZE - 1);

  // Control registers
  tlr_pkg::seq_state_t    state, state_next;
  tlr_pkg::line_status_t  line_status;
  logic [CW-1:0]          char_count;
  logic [CW-1:0]          line_length;
  logic [CW-1:0]          rd_idx;
  logic                   f_vld;
  logic [tlr_pkg::DATA_W-1:0] terminator;

  // Output register
  logic                       out_valid;
  logic [tlr_pkg::DATA_W-1:0] out_char;
  logic                       char_valid;
  logic                       out_last;
  tlr_pkg::line_status_t      out_state;

  // Datapath signals
  logic                       in_acc;
  logic                       is_byte;
  logic                       is_read;
  logic                       st_empty;
  logic                       is_term;
  logic                       is_full;
  logic                       has_line;
  logic                       ram_we;
  logic [tlr_pkg::DATA_W-1:0] ram_rdata;
  logic                       out_free;
  logic                       in_ready;
  logic                       issue;
  logic                       load;
  logic                       note_load;

  // Decode the input transaction
  assign in_acc   = rx_in.valid && in_ready;
  assign is_byte  = in_acc && (rx_in.mode == tlr_pkg::MODE_BYTE);
  assign is_read  = in_acc && (rx_in.mode == tlr_pkg::MODE_READ);
  assign st_empty = (line_status == tlr_pkg::ST_EMPTY);
  assign is_term  = (rx_in.rx_byte == terminator);
  assign is_full  = (char_count >= LAST_SLOT);
  assign has_line = (line_status == tlr_pkg::ST_READY) && (line_length != '0);
  assign ram_we   = is_byte && st_empty && !is_term && !is_full;
  assign out_free = !out_valid || line_out.ready;

  // Line store
  tlr_ram #(
    .WIDTH (tlr_pkg::DATA_W),
    .DEPTH (LINE_SIZE)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (char_count),
    .wdata (rx_in.rx_byte),
    .re    (issue),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tlr_pkg::S_IDLE: begin
        if (is_read) begin
          state_next = has_line ? tlr_pkg::S_READ : tlr_pkg::S_NOTE;
        end
      end
      tlr_pkg::S_READ: begin
        if (issue && (rd_idx == line_length - CW'(1))) begin
          state_next = tlr_pkg::S_DRAIN;
        end
      end
      tlr_pkg::S_DRAIN: begin
        if (load) begin
          state_next = tlr_pkg::S_IDLE;
        end
      end
      tlr_pkg::S_NOTE: begin
        if (out_free) begin
          state_next = tlr_pkg::S_IDLE;
        end
      end
      default: state_next = tlr_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    issue     = 1'b0;
    load      = 1'b0;
    note_load = 1'b0;
    unique case (state)
      tlr_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      tlr_pkg::S_READ: begin
        load  = f_vld && out_free;
        issue = !f_vld || out_free;
      end
      tlr_pkg::S_DRAIN: begin
        load = f_vld && out_free;
      end
      tlr_pkg::S_NOTE: begin
        note_load = out_free;
      end
      default: ;
    endcase
  end

  assign rx_in.ready = in_ready;
  assign cfg.ready   = 1'b1;

  // Advance sequencer and fetch tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= tlr_pkg::S_IDLE;
      rd_idx <= '0;
      f_vld  <= 1'b0;
    end else begin
      state <= state_next;
      if (is_read) begin
        rd_idx <= '0;
      end else if (issue) begin
        rd_idx <= rd_idx + CW'(1);
      end
      if (issue) begin
        f_vld <= 1'b1;
      end else if (load) begin
        f_vld <= 1'b0;
      end
    end
  end

  // Update line status and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      line_status <= tlr_pkg::ST_EMPTY;
      char_count  <= '0;
      line_length <= '0;
    end else if (is_read) begin
      line_status <= tlr_pkg::ST_EMPTY;
    end else if (is_byte && st_empty) begin
      if (is_term) begin
        line_status <= tlr_pkg::ST_READY;
        line_length <= char_count;
        char_count  <= '0;
      end else if (is_full) begin
        line_status <= tlr_pkg::ST_OVERFLOW;
        char_count  <= '0;
      end else begin
        char_count <= char_count + CW'(1);
      end
    end
  end

  // Hold terminator register
  always_ff @(posedge clk) begin
    if (rst) begin
      terminator <= tlr_pkg::TERM_RESET;
    end else if (cfg.valid && cfg.ready) begin
      terminator <= cfg.data;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load || note_load) begin
      out_valid <= 1'b1;
    end else if (line_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_char   <= ram_rdata;
      char_valid <= 1'b1;
      out_last   <= (state == tlr_pkg::S_DRAIN);
      out_state  <= line_status;
    end else if (note_load) begin
      out_char   <= '0;
      char_valid <= 1'b0;
      out_last   <= 1'b1;
      out_state  <= line_status;
    end
  end

  assign line_out.valid      = out_valid;
  assign line_out.out_char   = out_char;
  assign line_out.char_valid = char_valid;
  assign line_out.last       = out_last;
  assign line_out.line_state = out_state;

  // A pending fetch exists only while a line is being read
  `TLR_ASSERT(a_fetch_in_read, clk, rst, f_vld |-> (state == tlr_pkg::S_READ || state == tlr_pkg::S_DRAIN))
  // The line store is never written while it is being read out
  `TLR_ASSERT_NEVER(a_no_write_in_read, clk, rst, ram_we && (issue || f_vld))
  // Loading the final character ends the read
  `TLR_ASSERT(a_drain_ends, clk, rst, (state == tlr_pkg::S_DRAIN && load) |=> (state == tlr_pkg::S_IDLE))

endmodule
